/* rtl/rsh_pkg.sv */
package rsh_pkg;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned SUM_W   = 9;
   localparam int unsigned HDEN_W  = 11;
   localparam int unsigned REM_W   = 12;
   localparam int unsigned NUM_W   = 13;

   localparam logic [SUM_W-1:0] SUM_HALF = 9'd255;
   localparam logic [SUM_W:0]   SUM_FULL = 10'd510;

   typedef struct packed {
      logic                grey;
      logic [CHAN_W-1:0]   light;
      logic [SUM_W-1:0]    sat_den;
      logic [HDEN_W-1:0]   hue_den;
      logic [REM_W-1:0]    sat_rem;
      logic [REM_W-1:0]    hue_rem;
   } rsh_work_type;

endpackage

/* rtl/rgb_to_hsl_converter_core.sv */
// An accepted item passes two front stages, then one restoring-division
// stage per quotient bit, before it reaches rsp_valid.
// Throughput: one item per cycle while rsp_stall is low; every stage holds
// its own valid bit and empty stages fill while the output is stalled.
// Reset clears all valid bits; payload registers are not reset.
module rgb_to_hsl_converter_core #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [FRACTION_BITS:0]   rsp_hue,
   output logic [FRACTION_BITS:0]   rsp_saturation,
   output logic [7:0]               rsp_lightness
);
   import rsh_pkg::*;

   localparam int unsigned QW   = FRACTION_BITS + 1;
   localparam int unsigned NSTG = QW;

   logic             front_ready;
   logic             stg_valid [0:NSTG];
   logic             stg_ready [0:NSTG];
   rsh_work_type     stg_work  [0:NSTG];
   logic [QW-1:0]    stg_sat_q [0:NSTG];
   logic [QW-1:0]    stg_hue_q [0:NSTG];

   rsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_red     (req_red),
      .in_green   (req_green),
      .in_blue    (req_blue),
      .up_ready   (front_ready),
      .out_valid  (stg_valid[0]),
      .out_work   (stg_work[0]),
      .down_ready (stg_ready[0])
   );

   assign req_stall    = !front_ready;
   assign stg_sat_q[0] = '0;
   assign stg_hue_q[0] = '0;
   assign stg_ready[NSTG] = !rsp_stall;

   for (genvar i = 0; i < NSTG; i++) begin : g_div
      rsh_div_stage #(
         .QW    (QW),
         .FIRST (i == 0)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (stg_valid[i]),
         .in_work    (stg_work[i]),
         .in_sat_q   (stg_sat_q[i]),
         .in_hue_q   (stg_hue_q[i]),
         .up_ready   (stg_ready[i]),
         .out_valid  (stg_valid[i+1]),
         .out_work   (stg_work[i+1]),
         .out_sat_q  (stg_sat_q[i+1]),
         .out_hue_q  (stg_hue_q[i+1]),
         .down_ready (stg_ready[i+1])
      );
   end

   assign rsp_valid      = stg_valid[NSTG];
   assign rsp_hue        = stg_work[NSTG].grey ? '0 : stg_hue_q[NSTG];
   assign rsp_saturation = stg_work[NSTG].grey ? '0 : stg_sat_q[NSTG];
   assign rsp_lightness  = stg_work[NSTG].light;

endmodule

/* rtl/rsh_front.sv */
module rsh_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_red,
   input  logic [7:0]           in_green,
   input  logic [7:0]           in_blue,
   output logic                 up_ready,
   output logic                 out_valid,
   output rsh_pkg::rsh_work_type out_work,
   input  logic                 down_ready
);
   import rsh_pkg::*;

   // stage 1: extremes
   logic              v1_ff;
   logic [CHAN_W-1:0] r1_ff, g1_ff, b1_ff, mx1_ff, mn1_ff;
   logic              rmax1_ff, gmax1_ff;
   logic [CHAN_W-1:0] mx1_in, mn1_in;
   logic              rmax1_in, gmax1_in;
   logic              ready1, ready2;

   // stage 2: numerators and denominators
   logic         v2_ff;
   rsh_work_type work2_ff, work2_in;

   logic [CHAN_W-1:0] d;
   logic [SUM_W-1:0]  s;
   logic [SUM_W:0]    s_far;
   logic [NUM_W-1:0]  six_d, num, num_raw;

   assign ready2   = !v2_ff || down_ready;
   assign ready1   = !v1_ff || ready2;
   assign up_ready = ready1;

   always_comb begin
      mx1_in = in_red;
      mn1_in = in_red;
      if (in_green > mx1_in) mx1_in = in_green;
      if (in_blue > mx1_in) mx1_in = in_blue;
      if (in_green < mn1_in) mn1_in = in_green;
      if (in_blue < mn1_in) mn1_in = in_blue;
      rmax1_in = (in_red == mx1_in);
      gmax1_in = (in_green == mx1_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= in_valid;
      end
      if (ready1) begin
         r1_ff    <= in_red;
         g1_ff    <= in_green;
         b1_ff    <= in_blue;
         mx1_ff   <= mx1_in;
         mn1_ff   <= mn1_in;
         rmax1_ff <= rmax1_in;
         gmax1_ff <= gmax1_in;
      end
   end

   always_comb begin
      d     = mx1_ff - mn1_ff;
      s     = {1'b0, mx1_ff} + {1'b0, mn1_ff};
      s_far = SUM_FULL - {1'b0, s};
      six_d = {3'b0, d, 2'b0} + {4'b0, d, 1'b0};
      if (rmax1_ff) begin
         num_raw = {5'b0, g1_ff} - {5'b0, b1_ff};
      end else if (gmax1_ff) begin
         num_raw = {4'b0, d, 1'b0} + {5'b0, b1_ff} - {5'b0, r1_ff};
      end else begin
         num_raw = {3'b0, d, 2'b0} + {5'b0, r1_ff} - {5'b0, g1_ff};
      end
      num = num_raw[NUM_W-1] ? (num_raw + six_d) : num_raw;

      work2_in.grey    = (d == '0);
      work2_in.light   = s[SUM_W-1:1];
      work2_in.sat_den = (s < SUM_HALF) ? s : s_far[SUM_W-1:0];
      work2_in.hue_den = six_d[HDEN_W-1:0];
      work2_in.sat_rem = {4'b0, d};
      work2_in.hue_rem = num[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
      if (ready2) begin
         work2_ff <= work2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_work  = work2_ff;

endmodule

/* rtl/rsh_div_stage.sv */
module rsh_div_stage #(
   parameter int unsigned QW    = 17,
   parameter bit          FIRST = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rsh_pkg::rsh_work_type in_work,
   input  logic [QW-1:0]         in_sat_q,
   input  logic [QW-1:0]         in_hue_q,
   output logic                  up_ready,
   output logic                  out_valid,
   output rsh_pkg::rsh_work_type out_work,
   output logic [QW-1:0]         out_sat_q,
   output logic [QW-1:0]         out_hue_q,
   input  logic                  down_ready
);
   import rsh_pkg::*;

   logic              valid_ff;
   rsh_work_type      work_ff, work_in;
   logic [QW-1:0]     sat_q_ff, sat_q_in, hue_q_ff, hue_q_in;
   logic [REM_W-1:0]  sat_t, hue_t, sat_d, hue_d;
   logic              sat_bit, hue_bit;

   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      sat_t = FIRST ? in_work.sat_rem : {in_work.sat_rem[REM_W-2:0], 1'b0};
      hue_t = FIRST ? in_work.hue_rem : {in_work.hue_rem[REM_W-2:0], 1'b0};
      sat_d = {{(REM_W-SUM_W){1'b0}}, in_work.sat_den};
      hue_d = {{(REM_W-HDEN_W){1'b0}}, in_work.hue_den};
      sat_bit = (sat_t >= sat_d);
      hue_bit = (hue_t >= hue_d);
      work_in         = in_work;
      work_in.sat_rem = sat_bit ? (sat_t - sat_d) : sat_t;
      work_in.hue_rem = hue_bit ? (hue_t - hue_d) : hue_t;
      sat_q_in = {in_sat_q[QW-2:0], sat_bit};
      hue_q_in = {in_hue_q[QW-2:0], hue_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= in_valid;
      end
      if (up_ready) begin
         work_ff  <= work_in;
         sat_q_ff <= sat_q_in;
         hue_q_ff <= hue_q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;
   assign out_sat_q = sat_q_ff;
   assign out_hue_q = hue_q_ff;

   a_sat_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !work_ff.grey) |-> (work_ff.sat_rem < {3'b0, work_ff.sat_den}))
      else $error("saturation remainder not below denominator");

   a_hue_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !work_ff.grey) |-> (work_ff.hue_rem < {1'b0, work_ff.hue_den}))
      else $error("hue remainder not below denominator");

   a_held_item_stable: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !down_ready) |=>
         (valid_ff && $stable(sat_q_ff) && $stable(hue_q_ff) && $stable(work_ff)))
      else $error("held item changed in divider stage");

endmodule

/* test/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRACTION_BITS = 16;
   localparam int unsigned CHAN_W        = rsh_pkg::CHAN_W;
   localparam int unsigned LATENCY       = FRACTION_BITS + 3;
   localparam int unsigned RANDOM_PIXELS = 1100;
   localparam int unsigned IDLE_LIMIT    = 4000;
   localparam int unsigned HOLD_CYCLES   = 160;
   localparam int unsigned HOLD_AT       = 400;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      bit                drain_first;
   } pixel_type;

   typedef struct {
      logic [FRACTION_BITS:0] hue;
      logic [FRACTION_BITS:0] saturation;
      logic [CHAN_W-1:0]      lightness;
   } hsl_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHAN_W-1:0]      req_red = '0;
   logic [CHAN_W-1:0]      req_green = '0;
   logic [CHAN_W-1:0]      req_blue = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [FRACTION_BITS:0] rsp_hue;
   logic [FRACTION_BITS:0] rsp_saturation;
   logic [CHAN_W-1:0]      rsp_lightness;

   pixel_type   pixels[$];
   hsl_type     hsl_due[$];
   int unsigned errors = 0;
   logic        hold_on = 1'b0;

   rgb_to_hsl_converter_core #(
      .FRACTION_BITS (FRACTION_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness)
   );

   always #5 clock = ~clock;

   function automatic hsl_type hsl_of(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                      logic [CHAN_W-1:0] blue);
      int              r, g, b, hi, lo, d, s, num;
      longint unsigned q;
      hsl_type         o;
      r  = red;
      g  = green;
      b  = blue;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      d = hi - lo;
      s = hi + lo;
      o.lightness  = CHAN_W'(s >> 1);
      o.hue        = '0;
      o.saturation = '0;
      if (d != 0) begin
         q = (longint'(d) << FRACTION_BITS) / ((s < 255) ? s : 510 - s);
         o.saturation = q[FRACTION_BITS:0];
         if (r == hi) begin
            num = g - b;
         end else if (g == hi) begin
            num = 2 * d + b - r;
         end else begin
            num = 4 * d + r - g;
         end
         if (num < 0) num += 6 * d;
         q = (longint'(num) << FRACTION_BITS) / (6 * d);
         o.hue = q[FRACTION_BITS:0];
      end
      return o;
   endfunction

   task automatic add_pixel(int r, int g, int b, bit drain_first = 1'b0);
      pixel_type p;
      p.red         = CHAN_W'(r);
      p.green       = CHAN_W'(g);
      p.blue        = CHAN_W'(b);
      p.drain_first = drain_first;
      pixels.push_back(p);
   endtask

   function automatic int clamp_chan(int v);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
   endfunction

   // sender: bursts and gaps; a held item keeps its payload
   always @(posedge clock) begin
      int unsigned burst_left;
      int unsigned gap_left;
      logic        offer;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left   = 0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            hsl_due.push_back(hsl_of(req_red, req_green, req_blue));
            void'(pixels.pop_front());
            offer = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
         if (!offer && pixels.size() != 0) begin
            if (pixels[0].drain_first && hsl_due.size() != 0) begin
               offer = 1'b0;
            end else if (gap_left > 0 && !hold_on) begin
               gap_left--;
            end else begin
               offer = 1'b1;
               req_red   <= pixels[0].red;
               req_green <= pixels[0].green;
               req_blue  <= pixels[0].blue;
            end
         end
         req_valid <= offer;
      end
   end

   // receiver: stall pattern, one long hold-off, and result checks
   always @(posedge clock) begin
      int unsigned cycle_count;
      int unsigned phase_left;
      int unsigned stall_mode;
      int unsigned hold_left;
      logic        next_stall;
      hsl_type     want;
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_on     <= 1'b0;
         cycle_count = 0;
         phase_left  = 0;
         stall_mode  = 0;
         hold_left   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hsl_due.size() == 0) begin
               $error("result with nothing expected: hue %0d saturation %0d lightness %0d",
                      rsp_hue, rsp_saturation, rsp_lightness);
               errors++;
            end else begin
               want = hsl_due.pop_front();
               if (rsp_hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, rsp_hue);
                  errors++;
               end
               if (rsp_saturation !== want.saturation) begin
                  $error("saturation: expected %0d, got %0d", want.saturation, rsp_saturation);
                  errors++;
               end
               if (rsp_lightness !== want.lightness) begin
                  $error("lightness: expected %0d, got %0d", want.lightness, rsp_lightness);
                  errors++;
               end
            end
         end
         cycle_count++;
         if (cycle_count == HOLD_AT) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(20, 150);
               stall_mode = $urandom_range(0, 3);
            end
            phase_left--;
            case (stall_mode)
               0: next_stall = 1'b0;
               1: next_stall = ($urandom_range(0, 3) == 0);
               2: next_stall = ($urandom_range(0, 3) != 0);
               default: next_stall = ~rsp_stall;
            endcase
         end
         hold_on   <= (hold_left > 0);
         rsp_stall <= next_stall;
      end
   end

   always @(posedge clock) begin
      int unsigned idle_cycles;
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int kind, base, hi, lo, s;
      // grey pixels
      add_pixel(0, 0, 0);
      add_pixel(255, 255, 255);
      add_pixel(128, 128, 128);
      // pure primaries and secondaries, full saturation
      add_pixel(255, 0, 0);
      add_pixel(0, 255, 0);
      add_pixel(0, 0, 255);
      add_pixel(255, 255, 0);
      add_pixel(0, 255, 255);
      add_pixel(255, 0, 255);
      // red largest with green below blue (hue wraps), then green above blue
      add_pixel(200, 10, 60);
      add_pixel(200, 60, 10);
      // ties for the largest channel decide the sector by priority
      add_pixel(90, 90, 20);
      add_pixel(30, 90, 90);
      add_pixel(90, 30, 90);
      // dark/bright boundary of the channel sum
      add_pixel(200, 54, 100);
      add_pixel(200, 55, 100);
      add_pixel(128, 127, 127);
      add_pixel(127, 128, 128);
      // smallest contrast at both ends, then a middle and a full contrast
      add_pixel(1, 0, 0);
      add_pixel(255, 254, 254);
      add_pixel(0, 1, 1);
      add_pixel(170, 85, 85);
      add_pixel(1, 255, 0);

      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            5: begin
               base = $urandom_range(0, 255);
               add_pixel(clamp_chan(base + $urandom_range(0, 6) - 3),
                         clamp_chan(base + $urandom_range(0, 6) - 3),
                         clamp_chan(base + $urandom_range(0, 6) - 3), i == 550);
            end
            6: begin
               hi = $urandom_range(0, 255);
               lo = $urandom_range(0, hi);
               case ($urandom_range(0, 2))
                  0: add_pixel(hi, hi, lo, i == 550);
                  1: add_pixel(lo, hi, hi, i == 550);
                  default: add_pixel(hi, lo, hi, i == 550);
               endcase
            end
            7: begin
               hi = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255);
               lo = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, hi);
               case ($urandom_range(0, 5))
                  0: add_pixel(hi, lo, $urandom_range(lo, hi), i == 550);
                  1: add_pixel(hi, $urandom_range(lo, hi), lo, i == 550);
                  2: add_pixel(lo, hi, $urandom_range(lo, hi), i == 550);
                  3: add_pixel($urandom_range(lo, hi), hi, lo, i == 550);
                  4: add_pixel(lo, $urandom_range(lo, hi), hi, i == 550);
                  default: add_pixel($urandom_range(lo, hi), lo, hi, i == 550);
               endcase
            end
            8: begin
               base = $urandom_range(0, 255);
               add_pixel(base, base, base, i == 550);
            end
            9: begin
               s  = $urandom_range(252, 258);
               hi = $urandom_range((s + 1) / 2, (s > 255) ? 255 : s);
               lo = s - hi;
               add_pixel(hi, $urandom_range(lo, hi), lo, i == 550);
            end
            default: begin
               add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), i == 550);
            end
         endcase
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pixels.size() != 0 || hsl_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/rsh_pkg.sv
rtl/rsh_front.sv
rtl/rsh_div_stage.sv
rtl/rgb_to_hsl_converter_core.sv
test/testbench.sv
